FILE: src/bllr_pkg.sv
package bllr_pkg;

    // Command codes carried in s_tuser
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Per-item flags passed from the front end through the queue to the back end
    typedef struct packed {
        logic is_start;
        logic swapped;
        logic minor_down;
        logic color;
    } line_flags_t;

    localparam int FLAGS_W = $bits(line_flags_t);

endpackage

FILE: src/bllr_front.sv
module bllr_front #(
    parameter int COORD_BITS = 7
) (
    input  logic                      cmd,
    input  logic [COORD_BITS-1:0]     start_x,
    input  logic [COORD_BITS-1:0]     start_y,
    input  logic [COORD_BITS-1:0]     end_x,
    input  logic [COORD_BITS-1:0]     end_y,
    input  logic                      pen_color,
    output bllr_pkg::line_flags_t     flags,
    output logic [COORD_BITS-1:0]     major_pos,
    output logic [COORD_BITS-1:0]     major_end,
    output logic [COORD_BITS-1:0]     minor_pos,
    output logic [COORD_BITS-1:0]     major_delta,
    output logic [COORD_BITS-1:0]     minor_delta
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  swapped;
    logic [COORD_BITS-1:0] a0;
    logic [COORD_BITS-1:0] b0;
    logic [COORD_BITS-1:0] a1;
    logic [COORD_BITS-1:0] b1;
    logic                  reorder;
    logic [COORD_BITS-1:0] bs0;
    logic [COORD_BITS-1:0] bs1;

    // Pick the major axis from the absolute deltas
    always_comb begin
        dx      = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
        dy      = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
        swapped = (dy > dx);
        a0      = swapped ? start_y : start_x;
        b0      = swapped ? start_x : start_y;
        a1      = swapped ? end_y   : end_x;
        b1      = swapped ? end_x   : end_y;
    end

    // Order endpoints so the major coordinate ascends
    always_comb begin
        reorder     = (a0 > a1);
        major_pos   = reorder ? a1 : a0;
        major_end   = reorder ? a0 : a1;
        bs0         = reorder ? b1 : b0;
        bs1         = reorder ? b0 : b1;
        minor_pos   = bs0;
        major_delta = major_end - major_pos;
        minor_delta = (bs1 > bs0) ? (bs1 - bs0) : (bs0 - bs1);
    end

    // Classify the item
    always_comb begin
        flags.is_start   = (cmd == bllr_pkg::CMD_START);
        flags.swapped    = swapped;
        flags.minor_down = !(bs0 < bs1);
        flags.color      = pen_color;
    end

endmodule

FILE: src/bllr_fifo.sv
module bllr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != 2'(DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/bllr_back.sv
module bllr_back #(
    parameter int COORD_BITS = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  bllr_pkg::line_flags_t q_flags,
    input  logic [COORD_BITS-1:0] q_major_pos,
    input  logic [COORD_BITS-1:0] q_major_end,
    input  logic [COORD_BITS-1:0] q_minor_pos,
    input  logic [COORD_BITS-1:0] q_major_delta,
    input  logic [COORD_BITS-1:0] q_minor_delta,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  pixel_color,
    output logic                  pixel_valid,
    output logic                  last_pixel
);

    localparam int ERR_W = COORD_BITS + 2;

    // Line state
    logic [COORD_BITS-1:0] major_pos_reg,   major_pos_next;
    logic [COORD_BITS-1:0] major_end_reg,   major_end_next;
    logic [COORD_BITS-1:0] minor_pos_reg,   minor_pos_next;
    logic [COORD_BITS-1:0] major_delta_reg, major_delta_next;
    logic [COORD_BITS-1:0] minor_delta_reg, minor_delta_next;
    logic [ERR_W-1:0]      error_reg,       error_next;
    logic                  minor_down_reg,  minor_down_next;
    logic                  swapped_reg,     swapped_next;
    logic                  color_reg,       color_next;
    logic                  busy_reg,        busy_next;

    // Output stage
    logic                  out_valid_reg,   out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg,     pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg,     pixel_y_next;
    logic                  pixel_color_reg, pixel_color_next;
    logic                  pixel_valid_reg, pixel_valid_next;
    logic                  last_pixel_reg,  last_pixel_next;

    logic                  pop;
    logic                  cur_busy;
    logic                  last;
    logic [ERR_W-1:0]      err_sub;

    assign q_ready = !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    // Select loaded line or running state, then step the error term
    always_comb begin
        major_pos_next   = q_flags.is_start ? q_major_pos   : major_pos_reg;
        major_end_next   = q_flags.is_start ? q_major_end   : major_end_reg;
        minor_pos_next   = q_flags.is_start ? q_minor_pos   : minor_pos_reg;
        major_delta_next = q_flags.is_start ? q_major_delta : major_delta_reg;
        minor_delta_next = q_flags.is_start ? q_minor_delta : minor_delta_reg;
        minor_down_next  = q_flags.is_start ? q_flags.minor_down : minor_down_reg;
        swapped_next     = q_flags.is_start ? q_flags.swapped    : swapped_reg;
        color_next       = q_flags.is_start ? q_flags.color      : color_reg;
        error_next       = q_flags.is_start ? {2'b00, q_major_delta >> 1} : error_reg;
        cur_busy         = q_flags.is_start || busy_reg;

        last = (major_pos_next >= major_end_next);

        // Emit the current pixel, or an empty result while idle
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_color_next = pixel_color_reg;
        pixel_valid_next = pixel_valid_reg;
        last_pixel_next  = last_pixel_reg;
        if (pop) begin
            out_valid_next   = 1'b1;
            pixel_valid_next = cur_busy;
            if (cur_busy) begin
                pixel_x_next     = swapped_next ? minor_pos_next : major_pos_next;
                pixel_y_next     = swapped_next ? major_pos_next : minor_pos_next;
                pixel_color_next = color_next;
                last_pixel_next  = last;
            end else begin
                pixel_x_next     = '0;
                pixel_y_next     = '0;
                pixel_color_next = 1'b0;
                last_pixel_next  = 1'b0;
            end
        end

        // Step toward the next pixel
        err_sub = error_next - {2'b00, minor_delta_next};
        if (err_sub[ERR_W-1]) begin
            minor_pos_next = minor_down_next ? (minor_pos_next - 1'b1)
                                             : (minor_pos_next + 1'b1);
            error_next     = err_sub + {2'b00, major_delta_next};
        end else begin
            error_next     = err_sub;
        end
        busy_next = !last;
        if (!last) begin
            major_pos_next = major_pos_next + 1'b1;
        end
    end

    // Hold line state unless a pixel is produced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (pop && cur_busy) begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && cur_busy) begin
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_pos_reg   <= minor_pos_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            error_reg       <= error_next;
            minor_down_reg  <= minor_down_next;
            swapped_reg     <= swapped_next;
            color_reg       <= color_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
        pixel_valid_reg <= pixel_valid_next;
        last_pixel_reg  <= last_pixel_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign pixel_valid = pixel_valid_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

FILE: src/bresenham_line_rasterizer_unit.sv
// Path: an accepted item is written into the queue, then the pixel stage steps it
// into the output register.
// Throughput: one item per cycle while the result is not stalled; the pixel stage
// steps the error term, the minor coordinate and the major coordinate together.
// Reset: synchronous, active low; empties the queue, drops any line in progress and
// clears the output valid.
module bresenham_line_rasterizer_unit #(
    parameter int COORD_BITS = 7
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // start_x, start_y, end_x, end_y, pen_color (lowest bit up), zero fill
    input  logic [((4*COORD_BITS+1+7)/8)*8-1:0]          s_tdata,
    // cmd
    input  logic [0:0]                                   s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // pixel_x, pixel_y, pixel_color (lowest bit up), zero fill
    output logic [((2*COORD_BITS+1+7)/8)*8-1:0]          m_tdata,
    // pixel_valid
    output logic [0:0]                                   m_tuser,
    output logic                                         m_tlast
);

    localparam int N      = COORD_BITS;
    localparam int OUT_W  = ((2*N+1+7)/8)*8;
    localparam int QUE_W  = bllr_pkg::FLAGS_W + 5*N;

    bllr_pkg::line_flags_t f_flags;
    bllr_pkg::line_flags_t q_flags;
    logic [N-1:0]          f_major_pos, f_major_end, f_minor_pos, f_major_delta, f_minor_delta;
    logic [N-1:0]          q_major_pos, q_major_end, q_minor_pos, q_major_delta, q_minor_delta;
    logic [QUE_W-1:0]      q_wr_data;
    logic [QUE_W-1:0]      q_rd_data;
    logic                  q_valid;
    logic                  q_ready;
    logic [N-1:0]          pixel_x;
    logic [N-1:0]          pixel_y;
    logic                  pixel_color;

    // Classify and prepare each item
    bllr_front #(.COORD_BITS(N)) u_front (
        .cmd         (s_tuser[0]),
        .start_x     (s_tdata[N-1:0]),
        .start_y     (s_tdata[2*N-1:N]),
        .end_x       (s_tdata[3*N-1:2*N]),
        .end_y       (s_tdata[4*N-1:3*N]),
        .pen_color   (s_tdata[4*N]),
        .flags       (f_flags),
        .major_pos   (f_major_pos),
        .major_end   (f_major_end),
        .minor_pos   (f_minor_pos),
        .major_delta (f_major_delta),
        .minor_delta (f_minor_delta)
    );

    assign q_wr_data = {f_flags, f_minor_delta, f_major_delta, f_minor_pos,
                        f_major_end, f_major_pos};

    // Queue between front and back
    bllr_fifo #(.WIDTH(QUE_W)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (q_wr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rd_data)
    );

    assign {q_flags, q_minor_delta, q_major_delta, q_minor_pos,
            q_major_end, q_major_pos} = q_rd_data;

    // Step the line and hold the result
    bllr_back #(.COORD_BITS(N)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_flags       (q_flags),
        .q_major_pos   (q_major_pos),
        .q_major_end   (q_major_end),
        .q_minor_pos   (q_minor_pos),
        .q_major_delta (q_major_delta),
        .q_minor_delta (q_minor_delta),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_color   (pixel_color),
        .pixel_valid   (m_tuser[0]),
        .last_pixel    (m_tlast)
    );

    assign m_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

FILE: src/bllr_checker.sv
module bllr_checker #(
    parameter int COORD_BITS = 7
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [((4*COORD_BITS+1+7)/8)*8-1:0]  s_tdata,
    input logic [0:0]                           s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((2*COORD_BITS+1+7)/8)*8-1:0]  m_tdata,
    input logic [0:0]                           m_tuser,
    input logic                                 m_tlast
);

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result changed");

    // An empty result carries zeros and no last mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tlast)
        else $error("empty result carries data");

    // Reset leaves an empty queue and no pending result
    assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

    // An item accepted into an empty block yields a result on m_tvalid
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid && $past(!(s_tvalid && s_tready))
        |=> ##1 m_tvalid)
        else $error("result missing after accept");

endmodule

bind bresenham_line_rasterizer_unit bllr_checker #(.COORD_BITS(COORD_BITS)) u_bllr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
